>>> design/x86_alu_with_flags_defines.svh
// Assertion macros for the x86_alu_with_flags checker.
// Expects clk and rst in the scope of each use.
`ifndef X86_ALU_WITH_FLAGS_DEFINES_SVH
`define X86_ALU_WITH_FLAGS_DEFINES_SVH

// same-cycle implication, disabled in reset
`define XALU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define XALU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/xalu_pkg.sv
// Shared types and constants for the x86_alu_with_flags block.
// No dependencies.
`timescale 1ns / 1ps

package xalu_pkg;

  localparam int DataW = 16;
  localparam int FlagW = 12;

  localparam int CfPos = 0;
  localparam int PfPos = 2;
  localparam int AfPos = 4;
  localparam int ZfPos = 6;
  localparam int SfPos = 7;
  localparam int OfPos = 11;

  localparam logic [FlagW-1:0] CfBit      = 12'h001;
  localparam logic [FlagW-1:0] AfBit      = 12'h010;
  localparam logic [FlagW-1:0] OfBit      = 12'h800;
  localparam logic [FlagW-1:0] ArithMask  = 12'h8D5;
  localparam logic [FlagW-1:0] ArithNcMsk = 12'h8D4;
  localparam logic [FlagW-1:0] SzpMask    = 12'h0C4;

  localparam logic [7:0] DecHiLimit = 8'h99;
  localparam logic [7:0] DecLoStep  = 8'h06;
  localparam logic [7:0] DecHiStep  = 8'h60;

  typedef enum logic [3:0] {
    FnAdd = 4'd0,
    FnAdc = 4'd1,
    FnSub = 4'd2,
    FnSbb = 4'd3,
    FnAnd = 4'd4,
    FnOr  = 4'd5,
    FnXor = 4'd6,
    FnInc = 4'd7,
    FnDec = 4'd8,
    FnDaa = 4'd9,
    FnDas = 4'd10,
    FnAaa = 4'd11,
    FnAas = 4'd12
  } func_t;

  typedef struct packed {
    logic [3:0]       func;
    logic             wide;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
    logic [FlagW-1:0] flags;
  } req_t;

endpackage

>>> design/x86_alu_with_flags.sv
// Top level of the 8086-style ALU with flags: request register, ALU
// logic, result register. Depends on xalu_pkg and xalu_core.
//
// Usage:
//   Request channel: drive func, wide, operand_a, operand_b and flags_in
//   and raise start. The request is taken at a rising edge with start high
//   and busy low. busy is high only while rst is high, so outside reset a
//   request is taken every cycle that start is high.
//   Result channel: done is high for exactly one cycle with result and
//   flags_out valid. The receiver takes the result at the edge that ends
//   that cycle and cannot stall it.
//   Pipeline: the request register, then the ALU into the result register;
//   done is registered together with the result, and the result is taken
//   at the edge that ends the done cycle.
//   Throughput: one request per cycle outside reset; results come out in request order.
//   Reset: rst drops requests in flight and clears done. There is no state
//   beyond the pipeline, so nothing needs to be cleared afterwards.
`timescale 1ns / 1ps

module x86_alu_with_flags import xalu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [3:0]       func,
  input  logic             wide,
  input  logic [DataW-1:0] operand_a,
  input  logic [DataW-1:0] operand_b,
  input  logic [FlagW-1:0] flags_in,
  output logic             done,
  output logic [DataW-1:0] result,
  output logic [FlagW-1:0] flags_out
);

  req_t             req;
  logic             req_vld;
  logic [DataW-1:0] alu_res;
  logic [FlagW-1:0] alu_flags;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      req_vld <= start;
      done    <= req_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= '{func: func, wide: wide, operand_a: operand_a,
               operand_b: operand_b, flags: flags_in};
    end
    if (req_vld) begin
      result    <= alu_res;
      flags_out <= alu_flags;
    end
  end

  xalu_core u_core (
    .req       (req),
    .res       (alu_res),
    .res_flags (alu_flags)
  );

endmodule

>>> design/xalu_core.sv
// Combinational 8086-style ALU: add/sub family, logic, inc/dec, decimal
// and ascii adjusts, with flag update. Depends on xalu_pkg.
`timescale 1ns / 1ps

module xalu_core import xalu_pkg::*; (
  input  req_t             req,
  output logic [DataW-1:0] res,
  output logic [FlagW-1:0] res_flags
);

  function automatic logic [FlagW-1:0] szp(logic [DataW-1:0] r, logic w);
    logic [FlagW-1:0] f;
    f = '0;
    f[PfPos] = ~^r[7:0];
    f[ZfPos] = (r == '0);
    f[SfPos] = w ? r[15] : r[7];
    return f;
  endfunction

  logic [DataW-1:0] msk;
  logic [DataW-1:0] am;
  logic [DataW-1:0] bm;
  logic [DataW-1:0] ab;
  logic             ac;
  logic             is_sub;
  logic             use_cin;
  logic             use_one;
  logic [DataW:0]   sum;
  logic [DataW-1:0] ar;
  logic             acarry;
  logic             a_msb;
  logic             b_msb;
  logic             r_msb;
  logic             aovf;
  logic [FlagW-1:0] aflags;
  logic [DataW-1:0] lr;
  logic [FlagW-1:0] lflags;
  logic             sub_adj;
  logic [7:0]       al;
  logic [7:0]       ah;
  logic             old_cf;
  logic             lo_adj;
  logic             hi_adj;
  logic [7:0]       al1;
  logic [7:0]       al2;
  logic             c1;
  logic             dcf;
  logic [FlagW-1:0] dflags;
  logic [7:0]       ah_n;
  logic [DataW-1:0] xr;
  logic [FlagW-1:0] xflags;

  always_comb begin
    msk     = req.wide ? 16'hFFFF : 16'h00FF;
    am      = req.operand_a & msk;
    bm      = req.operand_b & msk;
    is_sub  = (req.func == FnSub) || (req.func == FnSbb) || (req.func == FnDec);
    use_cin = (req.func == FnAdc) || (req.func == FnSbb);
    use_one = (req.func == FnInc) || (req.func == FnDec);
    ab      = use_one ? 16'd1 : bm;
    ac      = use_cin & req.flags[CfPos];
    if (is_sub) begin
      sum = {1'b0, am} - {1'b0, ab} - {16'd0, ac};
    end else begin
      sum = {1'b0, am} + {1'b0, ab} + {16'd0, ac};
    end
    ar     = sum[DataW-1:0] & msk;
    acarry = req.wide ? sum[16] : sum[8];
    a_msb  = req.wide ? am[15] : am[7];
    b_msb  = req.wide ? ab[15] : ab[7];
    r_msb  = req.wide ? ar[15] : ar[7];
    aovf   = is_sub ? ((a_msb ^ b_msb) & (a_msb ^ r_msb))
                    : (~(a_msb ^ b_msb) & (a_msb ^ r_msb));
    aflags = (req.flags & ~(use_one ? ArithNcMsk : ArithMask)) | szp(ar, req.wide);
    if (!use_one) begin
      aflags[CfPos] = acarry;
    end
    aflags[OfPos] = aovf;
    aflags[AfPos] = am[4] ^ ab[4] ^ ar[4];
  end

  always_comb begin
    case (func_t'(req.func))
      FnAnd:   lr = am & bm;
      FnOr:    lr = am | bm;
      default: lr = am ^ bm;
    endcase
    lflags = (req.flags & ~(SzpMask | CfBit | AfBit | OfBit)) | szp(lr, req.wide);
  end

  always_comb begin
    sub_adj = (req.func == FnDas) || (req.func == FnAas);
    al      = req.operand_a[7:0];
    ah      = req.operand_a[15:8];
    old_cf  = req.flags[CfPos];
    lo_adj  = req.flags[AfPos] || (al[3:0] > 4'd9);
    hi_adj  = (al > DecHiLimit) || old_cf;
    al1     = al;
    c1      = 1'b0;
    dcf     = 1'b0;
    if (lo_adj) begin
      al1 = sub_adj ? (al - DecLoStep) : (al + DecLoStep);
      c1  = sub_adj ? (al < DecLoStep) : (al > 8'hF9);
      dcf = old_cf || c1;
    end
    al2 = al1;
    if (hi_adj) begin
      al2 = sub_adj ? (al1 - DecHiStep) : (al1 + DecHiStep);
      dcf = 1'b1;
    end else if (!sub_adj) begin
      dcf = 1'b0;
    end
    dflags = (req.flags & ~(CfBit | AfBit | SzpMask)) | szp({8'd0, al2}, 1'b0);
    dflags[CfPos] = dcf;
    dflags[AfPos] = lo_adj;

    ah_n   = sub_adj ? (ah - 8'd1) : (ah + 8'd1);
    xflags = req.flags;
    if (lo_adj) begin
      xr = {ah_n, 4'd0, al1[3:0]};
      xflags[CfPos] = 1'b1;
      xflags[AfPos] = 1'b1;
    end else begin
      xr = {ah, 4'd0, al[3:0]};
      xflags[CfPos] = 1'b0;
      xflags[AfPos] = 1'b0;
    end
  end

  always_comb begin
    case (func_t'(req.func))
      FnAdd, FnAdc, FnSub, FnSbb, FnInc, FnDec: begin
        res       = ar;
        res_flags = aflags;
      end
      FnAnd, FnOr, FnXor: begin
        res       = lr;
        res_flags = lflags;
      end
      FnDaa, FnDas: begin
        res       = {8'd0, al2};
        res_flags = dflags;
      end
      FnAaa, FnAas: begin
        res       = xr;
        res_flags = xflags;
      end
      default: begin
        res       = '0;
        res_flags = req.flags;
      end
    endcase
  end

endmodule

>>> design/xalu_checker.sv
// Port-level checks for x86_alu_with_flags, bound to the top level.
// Depends on xalu_pkg and x86_alu_with_flags_defines.svh.
`timescale 1ns / 1ps
`include "x86_alu_with_flags_defines.svh"

module xalu_checker import xalu_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic [3:0]       func,
  input logic             wide,
  input logic [FlagW-1:0] flags_in,
  input logic             done,
  input logic [DataW-1:0] result,
  input logic [FlagW-1:0] flags_out
);

  logic accepted;
  logic byte_op;
  logic logic_op;
  logic resv_op;
  logic cao_set;
  logic res_zero;

  assign accepted = start && !busy && !rst;
  assign byte_op  = !wide && (func <= FnDec);
  assign logic_op = (func == FnAnd) || (func == FnOr) || (func == FnXor);
  assign resv_op  = (func > FnAas);
  assign cao_set  = flags_out[CfPos] || flags_out[AfPos] || flags_out[OfPos];
  assign res_zero = (result == '0);

  `XALU_ASSERT_NEXT(a_req_done, start && !busy, ##1 done, "request without result")
  `XALU_ASSERT_IMPL(a_done_req, done, $past(accepted, 2), "result without request")
  `XALU_ASSERT_IMPL(a_byte_hi, done && $past(byte_op, 2), result[15:8] == '0, "byte high set")
  `XALU_ASSERT_IMPL(a_logic_clr, done && $past(logic_op, 2), !cao_set, "logic flag left set")
  `XALU_ASSERT_IMPL(a_unused, done && $past(resv_op, 2), res_zero && flags_out == $past(flags_in, 2), "unused")

endmodule

bind x86_alu_with_flags xalu_checker u_xalu_checker (.*);
